// ----- hw/rtl/fts_pkg.sv -----
// fts_pkg: transaction payload types, operation and status codes, control
// structs and sequencer states for the fifo thread scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fts_pkg;

    // thread id field width, fixed by the transaction format
    localparam int unsigned ID_FIELD_W = 5;

    // operation codes
    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_YIELD  = 2'd1;
    localparam logic [1:0] KIND_EXIT   = 2'd2;

    // target modes
    localparam logic [1:0] MODE_SPECIFIC = 2'd0;
    localparam logic [1:0] MODE_ANY      = 2'd1;
    localparam logic [1:0] MODE_SELF     = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_NONE    = 2'd2;
    localparam logic [1:0] STAT_NOMORE  = 2'd3;

    typedef struct packed {
        logic [1:0]            kind;
        logic [1:0]            target_mode;
        logic [ID_FIELD_W-1:0] target_id;
    } cmd_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [ID_FIELD_W-1:0] result_id;
        logic [ID_FIELD_W-1:0] running_now;
    } rsp_t;

    // control broadcast to every queue cell
    typedef struct packed {
        logic head_only;   // match cell zero instead of comparing the key
        logic remove_en;   // commit the compaction behind the matched cell
        logic push_en;     // write the push id at the push position
    } cell_ctrl_t;

    // id bitmap update
    typedef struct packed {
        logic set_free;    // claim the lowest free id
        logic clr_en;      // release clr_id
    } map_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fts_cell.sv -----
// fts_cell: one ready queue entry with key match and shift-left compaction
// depends on fts_pkg
`timescale 1ns / 1ps
`default_nettype none

module fts_cell #(
    parameter int unsigned IDX  = 0,
    parameter int unsigned IDW  = 5,
    parameter int unsigned CW   = 6
) (
    input  wire logic               clk,
    input  wire fts_pkg::cell_ctrl_t ctrl,
    input  wire logic [CW-1:0]      count,
    input  wire logic [IDW-1:0]     key,
    input  wire logic [IDW-1:0]     push_id,
    input  wire logic [CW-1:0]      push_pos,
    input  wire logic               shift_in,
    input  wire logic [IDW-1:0]     right_id,
    output logic                    shift_out,
    output logic [IDW-1:0]          id
);

    logic [IDW-1:0] id_reg;
    logic [IDW-1:0] id_next;
    logic           in_queue;
    logic           hit;

    // match against the key, only inside the occupied part of the queue
    always_comb
    begin
        in_queue = CW'(IDX) < count;
        if (ctrl.head_only)
        begin
            hit = in_queue && (IDX == 0);
        end
        else
        begin
            hit = in_queue && (id_reg == key);
        end
        shift_out = shift_in | hit;
    end

    // compaction from the right neighbour, then tail write
    always_comb
    begin
        id_next = id_reg;
        if (ctrl.remove_en && shift_out)
        begin
            id_next = right_id;
        end
        if (ctrl.push_en && (push_pos == CW'(IDX)))
        begin
            id_next = push_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id = id_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/fts_id_map.sv -----
// fts_id_map: bitmap of ids in use with lowest free id encoder
// depends on fts_pkg
`timescale 1ns / 1ps
`default_nettype none

module fts_id_map #(
    parameter int unsigned MAX_THREADS = 32,
    parameter int unsigned IDW         = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fts_pkg::map_ctrl_t ctrl,
    input  wire logic [IDW-1:0]     clr_id,
    output logic [IDW-1:0]          free_id
);

    logic [MAX_THREADS-1:0] used_reg;
    logic [MAX_THREADS-1:0] used_next;

    // lowest clear bit below the top id, the top id when none is clear
    always_comb
    begin
        free_id = IDW'(MAX_THREADS - 1);
        for (int i = MAX_THREADS - 2; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_id = IDW'(i);
            end
        end
    end

    // set and release
    always_comb
    begin
        used_next = used_reg;
        if (ctrl.set_free)
        begin
            used_next[free_id] = 1'b1;
        end
        if (ctrl.clr_en)
        begin
            used_next[clr_id] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= MAX_THREADS'(1);
        end
        else
        begin
            used_reg <= used_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fifo_thread_scheduler.sv -----
// fifo_thread_scheduler: top level, sequencer, running id, queue count and
// output register; depends on fts_pkg, fts_cell and fts_id_map
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    fts_pkg::cmd_t (kind, target_mode, target_id)
//   out      out  out_valid/out_stall  fts_pkg::rsp_t (status, result_id, running_now)
//
// each transaction is accepted into the command register, then executed in the
// execute state through the cell chain (match, compaction, tail write) and
// the lowest free id encoder of the id bitmap
// the execute cycle waits while the output register holds a stalled result;
// a new transaction is accepted while a result waits
// reset empties the queue, runs id 0 and marks only id 0 in use; queue cells
// are not reset and are read only below the count
`timescale 1ns / 1ps
`default_nettype none

module fifo_thread_scheduler #(
    parameter int unsigned MAX_THREADS = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire fts_pkg::cmd_t  in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output fts_pkg::rsp_t       out_data
);

    localparam int unsigned IDW = ($clog2(MAX_THREADS) > fts_pkg::ID_FIELD_W) ?
                                  $clog2(MAX_THREADS) : fts_pkg::ID_FIELD_W;
    localparam int unsigned CW  = $clog2(MAX_THREADS + 1);

    fts_pkg::state_t state_reg;
    fts_pkg::state_t state_next;
    fts_pkg::cmd_t   cmd_reg;
    fts_pkg::rsp_t   rsp_reg;
    fts_pkg::rsp_t   rsp_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [IDW-1:0]  running_reg;
    logic [IDW-1:0]  running_next;

    logic                in_fire;
    logic                exec_fire;
    fts_pkg::cell_ctrl_t cell_ctrl;
    fts_pkg::map_ctrl_t  map_ctrl;
    logic [IDW-1:0]      key;
    logic [IDW-1:0]      push_id;
    logic [CW-1:0]       push_pos;
    logic [IDW-1:0]      clr_id;
    logic [IDW-1:0]      free_id;
    logic [IDW-1:0]      tid;
    logic [IDW-1:0]      rid;
    logic [1:0]          status;
    logic                empty;
    logic                full;
    logic                found;
    logic                on_self;

    logic                shift_chain [MAX_THREADS+1];
    logic [IDW-1:0]      cell_id     [MAX_THREADS];

    // ready queue as a row of cells
    assign shift_chain[0] = 1'b0;

    for (genvar i = 0; i < MAX_THREADS; i++)
    begin : g_cell
        logic [IDW-1:0] right_id;
        if (i == MAX_THREADS - 1)
        begin : g_last
            assign right_id = cell_id[i];
        end
        else
        begin : g_mid
            assign right_id = cell_id[i+1];
        end

        fts_cell #(
            .IDX (i),
            .IDW (IDW),
            .CW  (CW)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .count     (count_reg),
            .key       (key),
            .push_id   (push_id),
            .push_pos  (push_pos),
            .shift_in  (shift_chain[i]),
            .right_id  (right_id),
            .shift_out (shift_chain[i+1]),
            .id        (cell_id[i])
        );
    end

    assign found = shift_chain[MAX_THREADS];

    // ids in use
    fts_id_map #(
        .MAX_THREADS (MAX_THREADS),
        .IDW         (IDW)
    ) u_id_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (map_ctrl),
        .clr_id  (clr_id),
        .free_id (free_id)
    );

    // handshakes
    assign in_stall  = (state_reg != fts_pkg::ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign exec_fire = (state_reg == fts_pkg::ST_EXEC) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fts_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = fts_pkg::ST_EXEC;
                end
            end
            fts_pkg::ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = fts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fts_pkg::ST_IDLE;
            end
        endcase
    end

    // operation decode
    always_comb
    begin
        tid     = IDW'(cmd_reg.target_id);
        empty   = (count_reg == '0);
        full    = ({1'b0, count_reg} + (CW+1)'(1)) >= (CW+1)'(MAX_THREADS);
        on_self = (cmd_reg.target_mode == fts_pkg::MODE_SELF) ||
                  ((cmd_reg.target_mode == fts_pkg::MODE_SPECIFIC) && (tid == running_reg));

        key                 = tid;
        cell_ctrl.head_only = !((cmd_reg.target_mode == fts_pkg::MODE_SPECIFIC) &&
                                (tid != running_reg));
        cell_ctrl.remove_en = 1'b0;
        cell_ctrl.push_en   = 1'b0;
        push_id             = running_reg;
        push_pos            = count_reg - CW'(1);
        map_ctrl.set_free   = 1'b0;
        map_ctrl.clr_en     = 1'b0;
        clr_id              = tid;
        count_next          = count_reg;
        running_next        = running_reg;
        status              = fts_pkg::STAT_INVALID;
        rid                 = '0;

        if (cmd_reg.kind == fts_pkg::KIND_CREATE)
        begin
            if (full)
            begin
                status = fts_pkg::STAT_NOMORE;
            end
            else
            begin
                map_ctrl.set_free = 1'b1;
                cell_ctrl.push_en = 1'b1;
                push_id           = free_id;
                push_pos          = count_reg;
                count_next        = count_reg + CW'(1);
                status            = fts_pkg::STAT_OK;
                rid               = free_id;
            end
        end
        else if ((cmd_reg.kind == fts_pkg::KIND_YIELD) &&
                 (cmd_reg.target_mode != fts_pkg::MODE_UNUSED))
        begin
            if (on_self)
            begin
                status = fts_pkg::STAT_OK;
                rid    = running_reg;
            end
            else if (cmd_reg.target_mode == fts_pkg::MODE_ANY)
            begin
                if (empty)
                begin
                    status = fts_pkg::STAT_NONE;
                end
                else
                begin
                    cell_ctrl.remove_en = 1'b1;
                    cell_ctrl.push_en   = 1'b1;
                    running_next        = cell_id[0];
                    status              = fts_pkg::STAT_OK;
                    rid                 = cell_id[0];
                end
            end
            else if (found)
            begin
                cell_ctrl.remove_en = 1'b1;
                cell_ctrl.push_en   = 1'b1;
                running_next        = tid;
                status              = fts_pkg::STAT_OK;
                rid                 = tid;
            end
        end
        else if ((cmd_reg.kind == fts_pkg::KIND_EXIT) &&
                 (cmd_reg.target_mode != fts_pkg::MODE_UNUSED))
        begin
            if (cmd_reg.target_mode == fts_pkg::MODE_ANY)
            begin
                if (empty)
                begin
                    status = fts_pkg::STAT_NONE;
                end
                else
                begin
                    cell_ctrl.remove_en = 1'b1;
                    map_ctrl.clr_en     = 1'b1;
                    clr_id              = cell_id[0];
                    count_next          = count_reg - CW'(1);
                    status              = fts_pkg::STAT_OK;
                    rid                 = cell_id[0];
                end
            end
            else if (on_self)
            begin
                if (empty)
                begin
                    status = fts_pkg::STAT_NONE;
                end
                else
                begin
                    cell_ctrl.remove_en = 1'b1;
                    map_ctrl.clr_en     = 1'b1;
                    clr_id              = running_reg;
                    running_next        = cell_id[0];
                    count_next          = count_reg - CW'(1);
                    status              = fts_pkg::STAT_OK;
                    rid                 = running_reg;
                end
            end
            else if (found)
            begin
                cell_ctrl.remove_en = 1'b1;
                map_ctrl.clr_en     = 1'b1;
                clr_id              = tid;
                count_next          = count_reg - CW'(1);
                status              = fts_pkg::STAT_OK;
                rid                 = tid;
            end
        end

        // only the execute cycle changes state
        if (!exec_fire)
        begin
            cell_ctrl.remove_en = 1'b0;
            cell_ctrl.push_en   = 1'b0;
            map_ctrl.set_free   = 1'b0;
            map_ctrl.clr_en     = 1'b0;
            count_next          = count_reg;
            running_next        = running_reg;
        end

        rsp_next.status      = status;
        rsp_next.result_id   = rid[fts_pkg::ID_FIELD_W-1:0];
        rsp_next.running_now = running_next[fts_pkg::ID_FIELD_W-1:0];
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fts_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            running_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            running_reg   <= running_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= in_data;
        end
        if (exec_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// testbench: self-checking bench for fifo_thread_scheduler, clocked driver and
// monitor with random idling, a built-in scheduler predictor and a stall watchdog
// depends on fts_pkg and fifo_thread_scheduler
`timescale 1ns / 1ps

module testbench;

    import fts_pkg::*;

    localparam int unsigned MAX_THREADS = 32;
    localparam int RANDOM_ITEMS = 1550;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 10;

    // command mix used by the random generator
    typedef enum int {
        MIX_BALANCED,
        MIX_FILL,
        MIX_DRAIN
    } mix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    cmd_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    rsp_t out_data;

    // scheduler state mirrored by the predictor
    logic [ID_FIELD_W-1:0] ready_q[$];
    logic [MAX_THREADS-1:0] ids_taken;
    logic [ID_FIELD_W-1:0] running_tid;

    // commands waiting to be driven, with the reply each one causes
    cmd_t pending_cmds[$];
    rsp_t pending_replies[$];
    // replies of accepted commands that have not come out yet
    rsp_t replies_due[$];

    int cmds_offered = 0;
    int cmds_accepted = 0;
    int rsps_seen = 0;
    int rsps_marked = 0;
    int in_gap = 0;
    int out_hold = 0;
    bit in_quiet = 1'b0;
    bit out_quiet = 1'b0;
    int idle_cycles = 0;
    int fail_count = 0;
    bit moved;
    rsp_t want;

    fifo_thread_scheduler #(
        .MAX_THREADS(MAX_THREADS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // position of a thread id in the ready queue, -1 when absent
    function automatic int find_ready(logic [ID_FIELD_W-1:0] tid);
        int pos;
        pos = -1;
        foreach (ready_q[i])
            if (pos < 0 && ready_q[i] == tid)
                pos = i;
        return pos;
    endfunction

    // advance the scheduler state by one command and return its reply
    function automatic rsp_t predict_sched_reply(cmd_t c);
        rsp_t r;
        int pos;
        int unsigned fid;
        logic [ID_FIELD_W-1:0] nxt;
        r.status = STAT_INVALID;
        r.result_id = '0;
        if (c.kind == KIND_CREATE)
        begin
            if (ready_q.size() + 1 >= MAX_THREADS)
                r.status = STAT_NOMORE;
            else
            begin
                // lowest free id, last id when none is free
                fid = 0;
                while (ids_taken[fid] && fid < MAX_THREADS - 1)
                    fid++;
                ids_taken[fid] = 1'b1;
                if (ready_q.size() < MAX_THREADS)
                    ready_q.push_back(fid[ID_FIELD_W-1:0]);
                r.status = STAT_OK;
                r.result_id = fid[ID_FIELD_W-1:0];
            end
        end
        else if (c.kind == KIND_YIELD && c.target_mode != MODE_UNUSED)
        begin
            if (c.target_mode == MODE_SELF ||
                (c.target_mode == MODE_SPECIFIC && c.target_id == running_tid))
            begin
                r.status = STAT_OK;
                r.result_id = running_tid;
            end
            else
            begin
                pos = (c.target_mode == MODE_ANY) ? 0 : find_ready(c.target_id);
                if (c.target_mode == MODE_ANY && ready_q.size() == 0)
                    r.status = STAT_NONE;
                else if (pos >= 0 && pos < ready_q.size())
                begin
                    // old thread to the tail, chosen thread runs
                    nxt = ready_q[pos];
                    ready_q.delete(pos);
                    ready_q.push_back(running_tid);
                    running_tid = nxt;
                    r.status = STAT_OK;
                    r.result_id = nxt;
                end
            end
        end
        else if (c.kind == KIND_EXIT && c.target_mode != MODE_UNUSED)
        begin
            if (c.target_mode == MODE_ANY)
            begin
                if (ready_q.size() == 0)
                    r.status = STAT_NONE;
                else
                begin
                    nxt = ready_q.pop_front();
                    ids_taken[nxt] = 1'b0;
                    r.status = STAT_OK;
                    r.result_id = nxt;
                end
            end
            else if (c.target_mode == MODE_SELF || c.target_id == running_tid)
            begin
                // running thread leaves, head of the queue takes over
                if (ready_q.size() == 0)
                    r.status = STAT_NONE;
                else
                begin
                    r.result_id = running_tid;
                    ids_taken[running_tid] = 1'b0;
                    running_tid = ready_q.pop_front();
                    r.status = STAT_OK;
                end
            end
            else
            begin
                pos = find_ready(c.target_id);
                if (pos >= 0)
                begin
                    nxt = ready_q[pos];
                    ready_q.delete(pos);
                    ids_taken[nxt] = 1'b0;
                    r.status = STAT_OK;
                    r.result_id = nxt;
                end
            end
        end
        r.running_now = running_tid;
        return r;
    endfunction

    // queue a command together with its predicted reply
    task automatic add_cmd(logic [1:0] kind, logic [1:0] mode, logic [ID_FIELD_W-1:0] tid);
        cmd_t c;
        c.kind = kind;
        c.target_mode = mode;
        c.target_id = tid;
        pending_cmds.push_back(c);
        pending_replies.push_back(predict_sched_reply(c));
    endtask

    // mostly well-formed commands aimed at live ids, some raw noise
    task automatic add_random_cmd(mix_t mix);
        logic [8:0] raw;
        int roll;
        logic [1:0] kind;
        logic [1:0] mode;
        logic [ID_FIELD_W-1:0] tid;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            raw = 9'($urandom_range(0, 511));
            add_cmd(raw[8:7], raw[6:5], raw[4:0]);
        end
        else
        begin
            roll = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:
                    kind = (roll < 60) ? KIND_CREATE : (roll < 85) ? KIND_YIELD : KIND_EXIT;
                MIX_DRAIN:
                    kind = (roll < 10) ? KIND_CREATE : (roll < 40) ? KIND_YIELD : KIND_EXIT;
                default:
                    kind = (roll < 34) ? KIND_CREATE : (roll < 67) ? KIND_YIELD : KIND_EXIT;
            endcase
            roll = $urandom_range(0, 99);
            mode = (roll < 50) ? MODE_SPECIFIC : (roll < 80) ? MODE_ANY : MODE_SELF;
            roll = $urandom_range(0, 99);
            if (roll < 60 && ready_q.size() > 0)
                tid = ready_q[$urandom_range(0, ready_q.size() - 1)];
            else if (roll < 80)
                tid = running_tid;
            else
                tid = ID_FIELD_W'($urandom_range(0, 31));
            add_cmd(kind, mode, tid);
        end
    endtask

    task automatic report_mismatch(string what, int got, int exp_val);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
        fail_count++;
    endtask

    // stimulus, reset and end of run
    initial
    begin
        mix_t mix;
        int left_in_mix;
        ids_taken = '0;
        ids_taken[0] = 1'b1;
        running_tid = '0;

        // empty queue cases, bad targets and unused codes
        add_cmd(KIND_YIELD, MODE_ANY, 5'd0);
        add_cmd(KIND_EXIT, MODE_ANY, 5'd0);
        add_cmd(KIND_EXIT, MODE_SELF, 5'd0);
        add_cmd(KIND_EXIT, MODE_SPECIFIC, 5'd0);
        add_cmd(KIND_YIELD, MODE_SELF, 5'd31);
        add_cmd(KIND_YIELD, MODE_SPECIFIC, 5'd0);
        add_cmd(KIND_YIELD, MODE_SPECIFIC, 5'd31);
        add_cmd(KIND_EXIT, MODE_SPECIFIC, 5'd31);
        add_cmd(2'd3, MODE_UNUSED, 5'd31);
        add_cmd(KIND_CREATE, MODE_UNUSED, 5'd31);
        add_cmd(KIND_CREATE, MODE_ANY, 5'd0);
        add_cmd(KIND_CREATE, MODE_SELF, 5'd0);
        add_cmd(KIND_YIELD, MODE_UNUSED, 5'd1);
        add_cmd(KIND_EXIT, MODE_UNUSED, 5'd1);
        // switches, removal from the middle, reuse of a freed id
        add_cmd(KIND_YIELD, MODE_ANY, 5'd0);
        add_cmd(KIND_YIELD, MODE_SPECIFIC, 5'd3);
        add_cmd(KIND_EXIT, MODE_SPECIFIC, 5'd0);
        add_cmd(KIND_CREATE, MODE_SPECIFIC, 5'd0);
        add_cmd(KIND_EXIT, MODE_ANY, 5'd0);
        add_cmd(KIND_EXIT, MODE_SELF, 5'd0);
        add_cmd(2'd3, MODE_SPECIFIC, 5'd0);
        add_cmd(KIND_YIELD, MODE_SPECIFIC, running_tid);
        add_cmd(KIND_EXIT, MODE_SPECIFIC, running_tid);

        // random part in phases of a balanced, a filling or a draining command mix
        mix = MIX_FILL;
        left_in_mix = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (left_in_mix == 0)
            begin
                case ($urandom_range(0, 2))
                    0: mix = MIX_BALANCED;
                    1: mix = MIX_FILL;
                    default: mix = MIX_DRAIN;
                endcase
                left_in_mix = $urandom_range(40, 90);
            end
            left_in_mix--;
            add_random_cmd(mix);
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_cmds.size() == 0 && cmds_accepted == cmds_offered &&
              replies_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && replies_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // command driver: one transaction per pending item, random gap before the next
    always @(negedge clk)
    begin
        if (rst_n && cmds_accepted == cmds_offered)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                in_data <= pending_cmds.pop_front();
                in_valid <= 1'b1;
                cmds_offered++;
                if ($urandom_range(0, 63) == 0)
                    in_quiet = !in_quiet;
                in_gap = in_quiet ? 0 : $urandom_range(0, 5);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // reply stall: random hold after every reply, with stretches of none
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsps_seen != rsps_marked)
            begin
                rsps_marked = rsps_seen;
                if ($urandom_range(0, 63) == 0)
                    out_quiet = !out_quiet;
                out_hold = out_quiet ? 0 : $urandom_range(0, 5);
            end
            if (out_hold > 0)
            begin
                out_hold--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // monitor: record accepted commands, check replies, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && !in_stall)
            begin
                cmds_accepted++;
                replies_due.push_back(pending_replies.pop_front());
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                rsps_seen++;
                moved = 1'b1;
                if (replies_due.size() == 0)
                    report_mismatch("reply with nothing due", out_data, 0);
                else
                begin
                    want = replies_due.pop_front();
                    if (out_data.status !== want.status)
                        report_mismatch("status", out_data.status, want.status);
                    if (out_data.result_id !== want.result_id)
                        report_mismatch("result_id", out_data.result_id, want.result_id);
                    if (out_data.running_now !== want.running_now)
                        report_mismatch("running_now", out_data.running_now,
                                        want.running_now);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no transaction for %0d cycles", $time, idle_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule

// ----- filelist.f -----
hw/rtl/fts_pkg.sv
hw/rtl/fts_cell.sv
hw/rtl/fts_id_map.sv
hw/rtl/fifo_thread_scheduler.sv
dv/testbench.sv
